### hdl/escape_sequence_decoder_core_defines.svh
// Assertion helpers shared by the decoder modules.
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ESD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ESD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/esd_pkg.sv
package esd_pkg;

    // Most results one input byte can cause
    localparam int unsigned MAX_RESULTS     = 6;
    localparam int unsigned RES_IDX_W       = $clog2(MAX_RESULTS);
    localparam int unsigned RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } res_t;

    // All results of one input byte, in emission order from entry 0
    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        res_t [MAX_RESULTS-1:0]       res;
    } job_t;

endpackage

### hdl/esd_in_if.sv
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

### hdl/esd_out_if.sv
interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input last_of_run,
                    output ready);
endinterface

### hdl/esd_front.sv
`include "escape_sequence_decoder_core_defines.svh"

module esd_front
(
    input  logic          clk,
    input  logic          rst_n,
    esd_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          push,
    output esd_pkg::job_t job
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX2   = 3'd2,
        MODE_HEX4   = 3'd3,
        MODE_HEX8   = 3'd4,
        MODE_OCT    = 3'd5
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_N_LO   = 8'h6E;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_T_LO   = 8'h74;
    localparam logic [7:0] CH_V_LO   = 8'h76;
    localparam logic [7:0] CH_H_LO   = 8'h68;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_U_UP   = 8'h55;

    localparam logic [3:0] HEX2_LEN = 4'd2;
    localparam logic [3:0] HEX4_LEN = 4'd4;
    localparam logic [3:0] HEX8_LEN = 4'd8;
    localparam logic [3:0] OCT_LEN  = 4'd3;

    mode_t       mode_reg, mode_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] val_reg, val_next;
    logic        start_reg, start_next;
    logic        failed_reg, failed_next;

    logic [7:0]  c;
    logic        eot;
    logic        take_fire;
    logic        is_hex, is_oct;
    logic [3:0]  hv;
    logic [3:0]  lim;
    logic [3:0]  cnt_inc;

    // take-step outputs
    logic        tk_fail, tk_byte, tk_flush, tk_plain;
    logic [7:0]  tk_byte_val;
    logic [31:0] tk_flush_val;
    mode_t       m1;
    logic [3:0]  n1;
    logic [31:0] v1;

    // digit-run conversion
    mode_t       fl_mode;
    logic [31:0] fl_val;
    logic        fl_uni, fl_fail;
    logic [2:0]  fl_n;
    logic [3:0][7:0] fl_bytes;

    esd_pkg::job_t jb;

    function automatic esd_pkg::job_t add_res(input esd_pkg::job_t j, input logic [7:0] d,
                                              input esd_pkg::kind_t k);
        esd_pkg::job_t r;
        r = j;
        r.res[j.count[esd_pkg::RES_IDX_W-1:0]] = '{data: d, kind: k};
        r.count = j.count + esd_pkg::RES_CNT_W'(1);
        return r;
    endfunction

    assign c           = in_ch.in_byte;
    assign eot         = in_ch.end_of_text;
    assign in_ch.ready = !q_full;
    assign take_fire   = in_ch.valid && in_ch.ready;
    assign cnt_inc     = cnt_reg + 4'd1;

    // character classes
    always_comb
    begin
        is_hex = 1'b1;
        hv     = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            hv = c[3:0];
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            hv = c[3:0] + 4'd9;
        else
            is_hex = 1'b0;
    end

    assign is_oct = (c[7:3] == 5'b00110);

    always_comb
    begin
        case (mode_reg)
            MODE_HEX2: lim = HEX2_LEN;
            MODE_HEX4: lim = HEX4_LEN;
            default:   lim = HEX8_LEN;
        endcase
    end

    // classify the byte against the current mode
    always_comb
    begin
        tk_fail      = 1'b0;
        tk_byte      = 1'b0;
        tk_byte_val  = 8'd0;
        tk_flush     = 1'b0;
        tk_flush_val = val_reg;
        tk_plain     = 1'b0;
        m1           = mode_reg;
        n1           = cnt_reg;
        v1           = val_reg;
        case (mode_reg)
            MODE_ESC:
            begin
                m1 = MODE_NORMAL;
                case (c)
                    CH_NL:
                    begin
                    end
                    CH_SQUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH, CH_LBRACE:
                    begin
                        tk_byte     = 1'b1;
                        tk_byte_val = c;
                    end
                    CH_A_LO: begin tk_byte = 1'b1; tk_byte_val = 8'd7;  end
                    CH_B_LO: begin tk_byte = 1'b1; tk_byte_val = 8'd8;  end
                    CH_F_LO: begin tk_byte = 1'b1; tk_byte_val = 8'd12; end
                    CH_N_LO: begin tk_byte = 1'b1; tk_byte_val = 8'd10; end
                    CH_R_LO: begin tk_byte = 1'b1; tk_byte_val = 8'd13; end
                    CH_T_LO: begin tk_byte = 1'b1; tk_byte_val = 8'd9;  end
                    CH_V_LO: begin tk_byte = 1'b1; tk_byte_val = 8'd11; end
                    CH_H_LO: begin m1 = MODE_HEX2; n1 = 4'd0; v1 = 32'd0; end
                    CH_U_LO: begin m1 = MODE_HEX4; n1 = 4'd0; v1 = 32'd0; end
                    CH_U_UP: begin m1 = MODE_HEX8; n1 = 4'd0; v1 = 32'd0; end
                    default:
                    begin
                        if (is_oct)
                        begin
                            m1 = MODE_OCT;
                            n1 = 4'd1;
                            v1 = {29'd0, c[2:0]};
                        end
                        else
                        begin
                            tk_fail = 1'b1;
                            n1      = 4'd0;
                            v1      = 32'd0;
                        end
                    end
                endcase
            end
            MODE_HEX2, MODE_HEX4, MODE_HEX8:
            begin
                if (is_hex)
                begin
                    v1 = {val_reg[27:0], hv};
                    n1 = cnt_inc;
                    if (cnt_inc >= lim)
                    begin
                        tk_flush     = 1'b1;
                        tk_flush_val = {val_reg[27:0], hv};
                        m1           = MODE_NORMAL;
                        n1           = 4'd0;
                        v1           = 32'd0;
                    end
                end
                else
                begin
                    if (cnt_reg == 4'd0)
                        tk_fail = 1'b1;
                    else
                    begin
                        tk_flush = 1'b1;
                        tk_plain = 1'b1;
                    end
                    m1 = MODE_NORMAL;
                    n1 = 4'd0;
                    v1 = 32'd0;
                end
            end
            MODE_OCT:
            begin
                if (is_oct)
                begin
                    v1 = {val_reg[28:0], c[2:0]};
                    n1 = cnt_inc;
                    if (cnt_inc >= OCT_LEN)
                    begin
                        tk_flush     = 1'b1;
                        tk_flush_val = {val_reg[28:0], c[2:0]};
                        m1           = MODE_NORMAL;
                        n1           = 4'd0;
                        v1           = 32'd0;
                    end
                end
                else
                begin
                    tk_flush = 1'b1;
                    tk_plain = 1'b1;
                    m1       = MODE_NORMAL;
                    n1       = 4'd0;
                    v1       = 32'd0;
                end
            end
            default:
                tk_plain = 1'b1;
        endcase
    end

    // convert a finished digit run: one byte, or UTF-8 for u/U
    assign fl_mode = tk_flush ? mode_reg : m1;
    assign fl_val  = tk_flush ? tk_flush_val : v1;
    assign fl_uni  = (fl_mode == MODE_HEX4) || (fl_mode == MODE_HEX8);
    assign fl_fail = fl_uni && ((fl_val > 32'h0010_FFFF) ||
                                (fl_val >= 32'h0000_D800 && fl_val <= 32'h0000_DFFF));

    always_comb
    begin
        fl_n     = 3'd1;
        fl_bytes = '0;
        if (!fl_uni || fl_val < 32'h80)
            fl_bytes[0] = fl_val[7:0];
        else if (fl_val < 32'h800)
        begin
            fl_n        = 3'd2;
            fl_bytes[0] = {3'b110, fl_val[10:6]};
            fl_bytes[1] = {2'b10, fl_val[5:0]};
        end
        else if (fl_val < 32'h1_0000)
        begin
            fl_n        = 3'd3;
            fl_bytes[0] = {4'b1110, fl_val[15:12]};
            fl_bytes[1] = {2'b10, fl_val[11:6]};
            fl_bytes[2] = {2'b10, fl_val[5:0]};
        end
        else
        begin
            fl_n        = 3'd4;
            fl_bytes[0] = {5'b11110, fl_val[20:18]};
            fl_bytes[1] = {2'b10, fl_val[17:12]};
            fl_bytes[2] = {2'b10, fl_val[11:6]};
            fl_bytes[3] = {2'b10, fl_val[5:0]};
        end
    end

    // assemble the results of this byte and the next state
    always_comb
    begin
        jb          = '0;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        failed_next = failed_reg;
        if (start_reg && eot)
        begin
            // one-byte text passes through
            jb = add_res(jb, c, esd_pkg::KIND_DATA);
            jb = add_res(jb, 8'd0, esd_pkg::KIND_OK);
        end
        else if (!failed_reg)
        begin
            mode_next = m1;
            cnt_next  = n1;
            val_next  = v1;
            if (tk_fail)
            begin
                jb          = add_res(jb, 8'd0, esd_pkg::KIND_FAIL);
                failed_next = 1'b1;
            end
            if (tk_byte)
                jb = add_res(jb, tk_byte_val, esd_pkg::KIND_DATA);
            if (tk_flush)
            begin
                if (fl_fail)
                begin
                    jb          = add_res(jb, 8'd0, esd_pkg::KIND_FAIL);
                    failed_next = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < 4; k++)
                        if (3'(k) < fl_n)
                            jb = add_res(jb, fl_bytes[k], esd_pkg::KIND_DATA);
                end
            end
            if (tk_plain && !failed_next)
            begin
                if (c == CH_BSLASH)
                    mode_next = MODE_ESC;
                else
                    jb = add_res(jb, c, esd_pkg::KIND_DATA);
            end
            // end of text: close any open escape or run
            if (eot && !failed_next)
            begin
                if (mode_next == MODE_ESC)
                begin
                    jb          = add_res(jb, 8'd0, esd_pkg::KIND_FAIL);
                    failed_next = 1'b1;
                end
                else if (mode_next == MODE_HEX2 || mode_next == MODE_HEX4 ||
                         mode_next == MODE_HEX8 || mode_next == MODE_OCT)
                begin
                    if (cnt_next == 4'd0 || fl_fail)
                    begin
                        jb          = add_res(jb, 8'd0, esd_pkg::KIND_FAIL);
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                            if (3'(k) < fl_n)
                                jb = add_res(jb, fl_bytes[k], esd_pkg::KIND_DATA);
                    end
                end
                if (!failed_next)
                    jb = add_res(jb, 8'd0, esd_pkg::KIND_OK);
            end
        end
        start_next = 1'b0;
        if (eot)
        begin
            mode_next   = MODE_NORMAL;
            cnt_next    = 4'd0;
            val_next    = 32'd0;
            start_next  = 1'b1;
            failed_next = 1'b0;
        end
    end

    assign push = take_fire && (jb.count != '0);
    assign job  = jb;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            cnt_reg    <= 4'd0;
            val_reg    <= 32'd0;
            start_reg  <= 1'b1;
            failed_reg <= 1'b0;
        end
        else if (take_fire)
        begin
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            val_reg    <= val_next;
            start_reg  <= start_next;
            failed_reg <= failed_next;
        end
    end

    `ESD_ASSERT_NOW(a_fail_closes_run, clk, rst_n, failed_reg, mode_reg == MODE_NORMAL && cnt_reg == 4'd0 && val_reg == 32'd0, "failed text left a run open")
    `ESD_ASSERT_NOW(a_start_not_failed, clk, rst_n, start_reg, !failed_reg && mode_reg == MODE_NORMAL, "text start with stale state")

endmodule

### hdl/esd_queue.sv
`include "escape_sequence_decoder_core_defines.svh"

module esd_queue #(
    parameter int unsigned DEPTH = esd_pkg::QUEUE_DEPTH_DEF  // 2 or more
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  esd_pkg::job_t wr_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output esd_pkg::job_t head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    esd_pkg::job_t      slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= wr_job;
    end

    `ESD_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full, "job pushed into full queue")
    `ESD_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty, "job popped from empty queue")

endmodule

### hdl/esd_back.sv
`include "escape_sequence_decoder_core_defines.svh"

module esd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  esd_pkg::job_t head,
    input  logic          q_empty,
    output logic          pop,
    esd_out_if.source     out_ch
);

    logic [esd_pkg::RES_IDX_W-1:0] idx_reg;
    logic                          valid_reg;
    logic [7:0]                    byte_reg;
    esd_pkg::kind_t                kind_reg;
    logic                          last_reg;

    esd_pkg::res_t cur;
    logic          load;
    logic          is_last;

    // walk the head job one result per cycle into the output register, while it is empty or being taken
    assign cur     = head.res[idx_reg];
    assign is_last = (esd_pkg::RES_CNT_W'(idx_reg) + esd_pkg::RES_CNT_W'(1)) == head.count;
    assign load    = !q_empty && (!valid_reg || out_ch.ready);
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= is_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ch.ready)
            valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= cur.data;
            kind_reg <= cur.kind;
            last_reg <= is_last;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.kind        = kind_reg;
    assign out_ch.last_of_run = last_reg;

    `ESD_ASSERT_NEXT(a_pop_rewinds, clk, rst_n, pop, idx_reg == '0, "result index not rewound after job")
    `ESD_ASSERT_NOW(a_status_is_last, clk, rst_n, valid_reg && kind_reg != esd_pkg::KIND_DATA, last_reg, "status result not last of its byte")

endmodule

### hdl/escape_sequence_decoder_core.sv
// Escape sequence decoder.
// in_ch carries one text byte per item plus end_of_text on the last byte of
// a text; out_ch carries decoded bytes (kind 0), then one status item per
// text: kind 1 when the text decoded cleanly, kind 2 on the first error
// (the rest of that text is then dropped). last_of_run marks the final
// result caused by one input byte; a byte may cause none (e.g. backslash).
// Both channels use valid/ready; an item moves when both are high.
// A byte accepted on in_ch has its results written to the job queue as one
// job, from whose head they are loaded into the output register.
// Throughput: one byte per cycle while each byte yields at most one result.
// The output side sends one result per cycle while the receiver is ready;
// a byte may yield up to 6 results (e.g. a 4-byte UTF-8 code point
// plus a trailing byte and status); the job queue of QUEUE_DEPTH entries
// absorbs such bursts and in_ch.ready drops only when that queue is full.
// A stalled receiver holds the output register and fills the queue.
// Reset clears decoder state, queue and output register; the first byte
// after reset starts a new text.
module escape_sequence_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    esd_in_if.sink     in_ch,
    esd_out_if.source  out_ch
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    esd_pkg::job_t wr_job;
    esd_pkg::job_t head;

    esd_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .job    (wr_job)
    );

    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .full   (q_full),
        .empty  (q_empty),
        .head   (head)
    );

    esd_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

### tb/sv/decoder_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the escape decoder, predicts the results of every
// accepted text byte and compares them in order with what the block sends.
module decoder_checker
(
    input  logic  clk,
    input  logic  rst_n,
    esd_in_if     in_mon,
    esd_out_if    out_mon,
    output int    fail_count,
    output int    pending_count,
    output int    results_checked,
    output int    texts_closed,
    output int    texts_failed
);

    typedef enum logic [2:0] {
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX2,
        MODE_HEX4,
        MODE_HEX8,
        MODE_OCT
    } esc_mode_t;

    typedef struct packed {
        logic [7:0]     out_byte;
        esd_pkg::kind_t kind;
        logic           last_of_run;
    } dec_result_t;

    // Decoder state as the block should hold it
    esc_mode_t   mode;
    logic [3:0]  ndigits;
    logic [31:0] code;
    logic        text_start;
    logic        text_failed;

    dec_result_t byte_results[$];     // results of the byte being decoded
    dec_result_t awaited_results[$];  // predicted, not yet seen on out_ch
    dec_result_t want;

    initial
    begin
        fail_count      = 0;
        results_checked = 0;
        texts_closed    = 0;
        texts_failed    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    function automatic void put(input logic [7:0] b, input esd_pkg::kind_t k);
        if (byte_results.size() < esd_pkg::MAX_RESULTS)
            byte_results.push_back('{out_byte: b, kind: k, last_of_run: 1'b0});
    endfunction

    function automatic void clear_run();
        mode    = MODE_TEXT;
        ndigits = '0;
        code    = '0;
    endfunction

    // First error of a text: one failure status, the rest of the text is dropped
    function automatic void mark_failed();
        put(8'h00, esd_pkg::KIND_FAIL);
        text_failed = 1'b1;
        clear_run();
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    // Convert a finished digit run; u and U go out as UTF-8
    function automatic void close_run();
        if (mode == MODE_HEX4 || mode == MODE_HEX8)
        begin
            if (code > 32'h10FFFF || (code >= 32'hD800 && code <= 32'hDFFF))
            begin
                mark_failed();
                return;
            end
            if (code < 32'h80)
            begin
                put(code[7:0], esd_pkg::KIND_DATA);
            end
            else if (code < 32'h800)
            begin
                put({3'b110, code[10:6]}, esd_pkg::KIND_DATA);
                put({2'b10, code[5:0]}, esd_pkg::KIND_DATA);
            end
            else if (code < 32'h10000)
            begin
                put({4'b1110, code[15:12]}, esd_pkg::KIND_DATA);
                put({2'b10, code[11:6]}, esd_pkg::KIND_DATA);
                put({2'b10, code[5:0]}, esd_pkg::KIND_DATA);
            end
            else
            begin
                put({5'b11110, code[20:18]}, esd_pkg::KIND_DATA);
                put({2'b10, code[17:12]}, esd_pkg::KIND_DATA);
                put({2'b10, code[11:6]}, esd_pkg::KIND_DATA);
                put({2'b10, code[5:0]}, esd_pkg::KIND_DATA);
            end
        end
        else
        begin
            // h and octal runs: low byte only
            put(code[7:0], esd_pkg::KIND_DATA);
        end
        clear_run();
    endfunction

    function automatic void plain_char(input logic [7:0] c);
        if (c == "\\")
            mode = MODE_ESC;
        else
            put(c, esd_pkg::KIND_DATA);
    endfunction

    // Byte right after a backslash
    function automatic void escape_char(input logic [7:0] c);
        mode = MODE_TEXT;
        case (c)
            "\n": ;  // line continuation, no output
            "'", "\"", "?", "\\", "{": put(c, esd_pkg::KIND_DATA);
            "a": put(8'h07, esd_pkg::KIND_DATA);
            "b": put(8'h08, esd_pkg::KIND_DATA);
            "f": put(8'h0C, esd_pkg::KIND_DATA);
            "n": put(8'h0A, esd_pkg::KIND_DATA);
            "r": put(8'h0D, esd_pkg::KIND_DATA);
            "t": put(8'h09, esd_pkg::KIND_DATA);
            "v": put(8'h0B, esd_pkg::KIND_DATA);
            "h": mode = MODE_HEX2;
            "u": mode = MODE_HEX4;
            "U": mode = MODE_HEX8;
            default:
            begin
                if (c >= "0" && c <= "7")
                begin
                    mode    = MODE_OCT;
                    ndigits = 4'd1;
                    code    = 32'(c - "0");
                end
                else
                begin
                    mark_failed();
                end
            end
        endcase
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int d;
        int max_digits;
        case (mode)
            MODE_ESC: escape_char(c);
            MODE_HEX2, MODE_HEX4, MODE_HEX8:
            begin
                max_digits = (mode == MODE_HEX2) ? 2 : (mode == MODE_HEX4) ? 4 : 8;
                d = hex_value(c);
                if (d >= 0)
                begin
                    code    = {code[27:0], 4'(d)};
                    ndigits = ndigits + 1'b1;
                    if (ndigits >= max_digits)
                        close_run();
                end
                else if (ndigits == 0)
                begin
                    mark_failed();
                end
                else
                begin
                    // a non-digit ends the run and is then read as text
                    close_run();
                    if (!text_failed)
                        plain_char(c);
                end
            end
            MODE_OCT:
            begin
                if (c >= "0" && c <= "7")
                begin
                    code    = code * 8 + 32'(c - "0");
                    ndigits = ndigits + 1'b1;
                    if (ndigits >= 3)
                        close_run();
                end
                else
                begin
                    close_run();
                    plain_char(c);
                end
            end
            default: plain_char(c);
        endcase
    endfunction

    // Text ends: an open escape fails, an open digit run is converted (or fails with no digit)
    function automatic void finish_text();
        if (mode == MODE_ESC)
        begin
            mark_failed();
        end
        else if (mode != MODE_TEXT)
        begin
            if (ndigits == 0)
                mark_failed();
            else
                close_run();
        end
        if (!text_failed)
            put(8'h00, esd_pkg::KIND_OK);
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic eot);
        byte_results.delete();
        if (text_start && eot)
        begin
            // one-byte text passes through as is
            put(c, esd_pkg::KIND_DATA);
            put(8'h00, esd_pkg::KIND_OK);
        end
        else if (!text_failed)
        begin
            take_char(c);
            if (eot && !text_failed)
                finish_text();
        end

        if (eot)
        begin
            clear_run();
            text_start  = 1'b1;
            text_failed = 1'b0;
        end
        else
        begin
            text_start = 1'b0;
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last_of_run = 1'b1;
        foreach (byte_results[i])
            awaited_results.push_back(byte_results[i]);
    endfunction

    // Input items are predicted before results of the same edge are checked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_run();
            text_start  = 1'b1;
            text_failed = 1'b0;
            awaited_results.delete();
            pending_count <= 0;
        end
        else
        begin
            if (in_mon.valid && in_mon.ready)
                decode_byte(in_mon.in_byte, in_mon.end_of_text);

            if (out_mon.valid && out_mon.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %02h kind %0d with nothing expected",
                                              out_mon.out_byte, out_mon.kind));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked = results_checked + 1;
                    if (out_mon.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_mon.out_byte, want.out_byte));
                    if (out_mon.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  out_mon.kind, want.kind));
                    if (out_mon.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                                  out_mon.last_of_run, want.last_of_run));
                    if (want.kind != esd_pkg::KIND_DATA)
                        texts_closed = texts_closed + 1;
                    if (want.kind == esd_pkg::KIND_FAIL)
                        texts_failed = texts_failed + 1;
                end
            end
            pending_count <= awaited_results.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_BYTES  = 28;
    localparam int DRAIN_CYCLES = 24;

    logic clk;
    logic rst_n;

    int   send_idle_pct = 28;
    int   recv_idle_pct = 47;
    logic hold_rx;
    logic pressure_go;
    int   bytes_sent = 0;
    int   cycle_count;

    int   fail_count;
    int   pending_count;
    int   results_checked;
    int   texts_closed;
    int   texts_failed;

    logic [7:0] text_q[$];

    // Second byte of every single-byte escape
    logic [7:0] simple_esc [0:12] = '{"\n", "'", "\"", "?", "\\", "{",
                                      "a", "b", "f", "n", "r", "t", "v"};
    // Stray bytes for broken escapes
    logic [7:0] noise_pool [0:11] = '{"\\", "\\", "h", "u", "U", "8",
                                      "9", "0", "7", "f", "z", "\n"};

    esd_in_if  in_ch();
    esd_out_if out_ch();

    escape_sequence_decoder_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    decoder_checker chk
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .results_checked (results_checked),
        .texts_closed    (texts_closed),
        .texts_failed    (texts_failed)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_count);
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls plus one long hold
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here
    initial
    begin
        hold_rx <= 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_str(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
        send_text();
    endtask

    function automatic int digits_for(input logic [31:0] v);
        int n;
        n = 1;
        while (n < 8 && (v >> (4 * n)) != 0)
            n++;
        return n;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 10)
            return 8'("0" + nib);
        return 8'(($urandom_range(1) ? "A" : "a") + nib - 10);
    endfunction

    task automatic add_hex(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            text_q.push_back(hex_char(v[4 * i +: 4]));
    endtask

    // One random token: plain byte, escape of each form, or noise
    task automatic add_token();
        int pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            text_q.push_back(8'($urandom_range(255)));
        end
        else if (pick < 50)
        begin
            text_q.push_back("\\");
            text_q.push_back(simple_esc[$urandom_range(12)]);
        end
        else if (pick < 58)
        begin
            v = $urandom_range(255);
            text_q.push_back("\\");
            text_q.push_back("h");
            add_hex(v, $urandom_range(2, digits_for(v)));
        end
        else if (pick < 70)
        begin
            case ($urandom_range(7))
                0, 1:    v = $urandom_range(32'h7F);
                2, 3:    v = $urandom_range(32'h7FF, 32'h80);
                7:       v = $urandom_range(32'hDFFF, 32'hD800);
                default: v = $urandom_range(32'hFFFF, 32'h800);
            endcase
            text_q.push_back("\\");
            text_q.push_back("u");
            add_hex(v, $urandom_range(4, digits_for(v)));
        end
        else if (pick < 80)
        begin
            case ($urandom_range(7))
                5:       v = $urandom_range(1) ? 32'h10FFFF : 32'h0;
                6:       v = $urandom_range(32'hFFFF);
                7:       v = $urandom();
                default: v = $urandom_range(32'h10FFFF, 32'h10000);
            endcase
            text_q.push_back("\\");
            text_q.push_back("U");
            add_hex(v, $urandom_range(8, digits_for(v)));
        end
        else if (pick < 90)
        begin
            text_q.push_back("\\");
            repeat ($urandom_range(3, 1))
                text_q.push_back(8'("0" + $urandom_range(7)));
        end
        else
        begin
            repeat ($urandom_range(3, 1))
                text_q.push_back(noise_pool[$urandom_range(11)]);
        end
    endtask

    task automatic send_random_text();
        text_q.delete();
        if ($urandom_range(99) < 8)
        begin
            text_q.push_back(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(6, 1)) add_token();
            // occasionally a dangling backslash at the end
            if ($urandom_range(99) < 5)
                text_q.push_back("\\");
        end
        send_text();
    endtask

    task automatic run_phase(input int budget);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < budget)
            send_random_text();
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.in_byte     <= 8'h00;
        in_ch.end_of_text <= 1'b0;
        pressure_go       <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte texts at both extremes, error paths, open runs
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_str("\\qz");        // unknown escape, tail dropped
        send_str("a\\");         // dangling backslash
        send_str("\\ud800");     // surrogate code point
        send_str("\\hG");        // h with no digit
        send_str("\\\nx");       // line continuation
        send_str("\\7");         // text ends inside an octal run
        send_str("\\u");         // bare u at the end

        run_phase(PHASE_BYTES);

        send_idle_pct = 47;
        recv_idle_pct <= 28;
        run_phase(PHASE_BYTES);

        // No idling; the receiver hold backs the block up into its input
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        pressure_go   <= 1'b1;
        run_phase(PHASE_BYTES);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d text bytes sent, %0d texts closed (%0d with an error)",
                 bytes_sent, texts_closed, texts_failed);
        $display("%0d results checked; idle mixes 28/47, 47/28 and none, plus a %0d-cycle hold",
                 results_checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
